/* rtl/typewriter_page_grid_editor_macros.svh */
// ---------------------------------------------------------------------------
// Typewriter page grid editor assertion macros
// Shared property forms for the concurrent checks of the editor.
// ---------------------------------------------------------------------------
`ifndef TYPEWRITER_PAGE_GRID_EDITOR_MACROS_SVH
`define TYPEWRITER_PAGE_GRID_EDITOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPGE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TPGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tpge_pkg.sv */
// ---------------------------------------------------------------------------
// tpge_pkg
// Shared sizes, codes, item layouts and controller/datapath types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpge_pkg;

    localparam int MAX_COLS  = 128;
    localparam int MAX_ROWS  = 64;
    localparam int MAX_PAGES = 8;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int PAGE_W = $clog2(MAX_PAGES);
    localparam int CNT_W  = PAGE_W + 1;
    localparam int ADDR_W = PAGE_W + ROW_W + COL_W;
    localparam int BLK_W  = ROW_W + COL_W;

    localparam int IN_W       = 27;
    localparam int OUT_W      = 29;
    localparam int TDATA_W    = 32;

    localparam logic [7:0] SPACE      = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;

    localparam logic [2:0] OP_TYPE  = 3'd0;
    localparam logic [2:0] OP_BACK  = 3'd1;
    localparam logic [2:0] OP_DEL   = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [1:0] CFG_LINE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_PAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_INSERT      = 2'd2;
    localparam logic [1:0] CFG_WRAP        = 2'd3;

    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(MAX_PAGES - 1);

    typedef struct packed {
        logic [6:0] read_col;
        logic [5:0] read_row;
        logic [2:0] read_page;
        logic [7:0] char_code;
        logic [2:0] opcode;
    } tpge_in_t;

    typedef struct packed {
        logic       page_limit_hit;
        logic [7:0] cell_value;
        logic [3:0] pages_used;
        logic [6:0] cursor_col;
        logic [5:0] cursor_row;
        logic [2:0] cursor_page;
    } tpge_out_t;

    typedef enum logic [5:0] {
        U_NOP, U_START, U_CLEAR, U_BLANK, U_RD_CELL, U_CELL_OUT,
        U_BS_COL, U_BS_ROW, U_BS_PAGE, U_PS_RD, U_PS_CHK,
        U_DEL_INIT, U_DL_RD, U_DL_WR, U_WR_LAST, U_WR_CUR_SP,
        U_INS_INIT, U_IN_RD, U_IN_WR, U_WR_CHAR,
        U_NEWLINE, U_CR, U_NP_GO, U_NP_FAIL_NL, U_NP_FAIL_HW,
        U_SW_INIT, U_SW_RD, U_SW1_CHK, U_SW2_CHK, U_SW3_INIT, U_SW3_RD, U_K_INC,
        U_SW_TGT, U_CP_RD, U_CP_WR, U_CP_SP, U_OLD_INIT, U_OLD_BL, U_SW_FIN
    } tpge_uop_t;

    typedef struct packed {
        logic [2:0] op;
        logic       ch_nl;
        logic       ch_cr;
        logic       ch_ctl;
        logic       shift_ok;
        logic       col_end;
        logic       row_last;
        logic       col_zero;
        logic       row_zero;
        logic       page_zero;
        logic       np_over;
        logic       np_new;
        logic       rd_space;
        logic       k_zero;
        logic       k_end;
        logic       del_end;
        logic       ins_end;
        logic       src_in;
        logic       ps_end;
        logic       blank_end;
        logic       wrap_en;
    } tpge_stat_t;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [PAGE_W-1:0] p,
        input logic [ROW_W-1:0]  r,
        input logic [COL_W-1:0]  c
    );
        return {p, r, c};
    endfunction

endpackage

/* rtl/typewriter_page_grid_editor.sv */
// ---------------------------------------------------------------------------
// typewriter_page_grid_editor
// Keystroke-driven page grid text store with cursor, wrap and page growth.
// ---------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_axis    in         one keystroke or cell read per transaction
//  m_axis    out        cursor, page count, cell byte and limit flag per step
//  cfg       in         register writes: width, height, insert, wrap
//
//  Row shifts, soft wrap and a backspace across a page step through the cell
//  memory one cell at a time, each cell read before it is moved or checked.
//  A new page or a clear blanks MAX_ROWS*MAX_COLS (8192) cells, one per cycle.
//  After reset page 0 is blanked before the first transaction.
//  A waiting result holds the sequencer at its last step until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module typewriter_page_grid_editor
    import tpge_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // opcode[2:0], char_code[10:3], read_page[13:11], read_row[19:14], read_col[26:20]
    input  logic [TDATA_W-1:0] s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // cursor_page[2:0], cursor_row[8:3], cursor_col[15:9], pages_used[19:16],
    // cell_value[27:20], page_limit_hit[28]
    output logic [TDATA_W-1:0] m_axis_tdata,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [7:0]         cfg_wdata
);

`include "typewriter_page_grid_editor_macros.svh"

    logic [7:0] line_width_reg;
    logic [6:0] page_height_reg;
    logic       insert_reg;
    logic       wrap_reg;

    logic       out_valid_reg, out_valid_next;
    tpge_out_t  out_data_reg;

    tpge_uop_t  uop;
    tpge_stat_t stat;
    tpge_out_t  result;
    tpge_in_t   in_item;
    logic       in_ready;
    logic       done;
    logic       out_free;

    logic       in_accept;
    logic       pages_ok;
    logic       page_alloc_ok;

    assign in_item  = tpge_in_t'(s_axis_tdata[IN_W-1:0]);
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= 8'd80;
            page_height_reg <= 7'd24;
            insert_reg      <= 1'b0;
            wrap_reg        <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_LINE_WIDTH:  line_width_reg  <= cfg_wdata;
                CFG_PAGE_HEIGHT: page_height_reg <= cfg_wdata[6:0];
                CFG_INSERT:      insert_reg      <= cfg_wdata[0];
                CFG_WRAP:        wrap_reg        <= cfg_wdata[0];
                default:         wrap_reg        <= wrap_reg;
            endcase
        end
    end

    tpge_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .uop      (uop),
        .in_ready (in_ready),
        .done     (done)
    );

    tpge_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .uop           (uop),
        .in_item       (in_item),
        .line_width    (line_width_reg),
        .page_height   (page_height_reg),
        .insert_enable (insert_reg),
        .wrap_enable   (wrap_reg),
        .stat          (stat),
        .result        (result)
    );

    always_comb
    begin
        if (done)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_data_reg <= result;
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W - OUT_W){1'b0}}, out_data_reg};

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign pages_ok      = (out_data_reg.pages_used != 4'd0)
                        && (out_data_reg.pages_used <= 4'(MAX_PAGES));
    assign page_alloc_ok = {1'b0, out_data_reg.cursor_page} < out_data_reg.pages_used;

    `TPGE_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_axis_tready, "input accepted mid-step")
    `TPGE_ASSERT_SAME(a_pages_range, m_axis_tvalid, pages_ok, "page count out of range")
    `TPGE_ASSERT_SAME(a_cursor_page, m_axis_tvalid, page_alloc_ok, "cursor page not allocated")

endmodule

/* rtl/tpge_dpath.sv */
// ---------------------------------------------------------------------------
// tpge_dpath
// Cell store, cursor, page count and scan registers, driven by micro-ops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpge_dpath
    import tpge_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tpge_uop_t   uop,
    input  tpge_in_t    in_item,
    input  logic [7:0]  line_width,
    input  logic [6:0]  page_height,
    input  logic        insert_enable,
    input  logic        wrap_enable,
    output tpge_stat_t  stat,
    output tpge_out_t   result
);

    logic [7:0]       mem [0:(1 << ADDR_W) - 1];
    logic [7:0]       rd_data_reg;

    logic [PAGE_W-1:0] page_reg, page_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              limit_reg, limit_next;
    logic [7:0]        cell_reg, cell_next;
    logic [PAGE_W-1:0] bp_reg, bp_next;
    logic [BLK_W-1:0]  bc_reg, bc_next;

    logic [COL_W-1:0]  k_reg, k_next;
    logic [ROW_W-1:0]  sr_reg, sr_next;
    logic [COL_W-1:0]  sp_reg, sp_next;
    logic [COL_W-1:0]  last_reg, last_next;
    logic [PAGE_W-1:0] tp_reg, tp_next;
    logic [ROW_W-1:0]  tr_reg, tr_next;
    tpge_in_t          item_reg, item_next;

    logic [7:0]        cols;
    logic [6:0]        rows;
    logic [7:0]        cols_m1;
    logic [6:0]        rows_m1;
    logic [COL_W-1:0]  cmax;
    logic [ROW_W-1:0]  rmax;
    logic              in_range;

    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [ADDR_W-1:0] ra;
    logic [7:0]        wd;

    always_comb
    begin
        if (line_width == 8'd0)
            cols = 8'd1;
        else if (line_width > 8'(MAX_COLS))
            cols = 8'(MAX_COLS);
        else
            cols = line_width;
        if (page_height == 7'd0)
            rows = 7'd1;
        else if (page_height > 7'(MAX_ROWS))
            rows = 7'(MAX_ROWS);
        else
            rows = page_height;
        cols_m1 = cols - 8'd1;
        rows_m1 = rows - 7'd1;
        cmax    = cols_m1[COL_W-1:0];
        rmax    = rows_m1[ROW_W-1:0];
    end

    assign in_range = ({1'b0, item_reg.read_page} < cnt_reg)
                   && ({1'b0, item_reg.read_row} < rows)
                   && ({1'b0, item_reg.read_col} < cols);

    always_comb
    begin
        stat.op        = item_reg.opcode;
        stat.ch_nl     = item_reg.char_code == CH_NEWLINE;
        stat.ch_cr     = item_reg.char_code == CH_RETURN;
        stat.ch_ctl    = item_reg.char_code < SPACE;
        stat.shift_ok  = insert_enable && (col_reg < cmax);
        stat.col_end   = col_reg == cmax;
        stat.row_last  = row_reg == rmax;
        stat.col_zero  = col_reg == '0;
        stat.row_zero  = row_reg == '0;
        stat.page_zero = page_reg == '0;
        stat.np_over   = page_reg == PAGE_LAST;
        stat.np_new    = ({1'b0, page_reg} + CNT_W'(1)) >= cnt_reg;
        stat.rd_space  = rd_data_reg == SPACE;
        stat.k_zero    = k_reg == '0;
        stat.k_end     = k_reg == cmax;
        stat.del_end   = ({1'b0, k_reg} + 8'd1) == {1'b0, cmax};
        stat.ins_end   = {1'b0, k_reg} == ({1'b0, col_reg} + 8'd1);
        stat.src_in    = ({1'b0, sp_reg} + {1'b0, k_reg} + 8'd1) < cols;
        stat.ps_end    = (k_reg == '0) && (sr_reg == '0);
        stat.blank_end = &bc_reg;
        stat.wrap_en   = wrap_enable;
    end

    always_comb
    begin
        page_next  = page_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cnt_next   = cnt_reg;
        limit_next = limit_reg;
        cell_next  = cell_reg;
        bp_next    = bp_reg;
        bc_next    = bc_reg;
        k_next     = k_reg;
        sr_next    = sr_reg;
        sp_next    = sp_reg;
        last_next  = last_reg;
        tp_next    = tp_reg;
        tr_next    = tr_reg;
        item_next  = item_reg;
        we         = 1'b0;
        wa         = cell_addr(page_reg, row_reg, k_reg);
        wd         = SPACE;
        ra         = cell_addr(page_reg, row_reg, k_reg);
        case (uop)
            U_START:
            begin
                item_next  = in_item;
                limit_next = 1'b0;
                cell_next  = 8'd0;
                col_next   = (col_reg > cmax) ? cmax : col_reg;
                row_next   = (row_reg > rmax) ? rmax : row_reg;
            end
            U_CLEAR:
            begin
                page_next = '0;
                row_next  = '0;
                col_next  = '0;
                cnt_next  = CNT_W'(1);
                bp_next   = '0;
                bc_next   = '0;
            end
            U_BLANK:
            begin
                we      = 1'b1;
                wa      = {bp_reg, bc_reg};
                bc_next = bc_reg + BLK_W'(1);
            end
            U_RD_CELL:
            begin
                ra = cell_addr(item_reg.read_page, item_reg.read_row, item_reg.read_col);
            end
            U_CELL_OUT:
            begin
                cell_next = in_range ? rd_data_reg : SPACE;
            end
            U_BS_COL:
            begin
                col_next = col_reg - COL_W'(1);
            end
            U_BS_ROW:
            begin
                row_next = row_reg - ROW_W'(1);
                col_next = cmax;
            end
            U_BS_PAGE:
            begin
                page_next = page_reg - PAGE_W'(1);
                k_next    = cmax;
                sr_next   = rmax;
            end
            U_PS_RD:
            begin
                ra = cell_addr(page_reg, sr_reg, k_reg);
            end
            U_PS_CHK:
            begin
                if (!stat.rd_space)
                begin
                    row_next = sr_reg;
                    col_next = k_reg;
                end
                else if (stat.ps_end)
                begin
                    row_next = '0;
                    col_next = '0;
                end
                else if (k_reg == '0)
                begin
                    k_next  = cmax;
                    sr_next = sr_reg - ROW_W'(1);
                end
                else
                begin
                    k_next = k_reg - COL_W'(1);
                end
            end
            U_DEL_INIT:
            begin
                k_next = col_reg;
            end
            U_DL_RD:
            begin
                ra = cell_addr(page_reg, row_reg, k_reg + COL_W'(1));
            end
            U_DL_WR:
            begin
                we     = 1'b1;
                wd     = rd_data_reg;
                k_next = k_reg + COL_W'(1);
            end
            U_WR_LAST:
            begin
                we = 1'b1;
                wa = cell_addr(page_reg, row_reg, cmax);
            end
            U_WR_CUR_SP:
            begin
                we = 1'b1;
                wa = cell_addr(page_reg, row_reg, col_reg);
            end
            U_INS_INIT:
            begin
                k_next = cmax;
            end
            U_IN_RD:
            begin
                ra = cell_addr(page_reg, row_reg, k_reg - COL_W'(1));
            end
            U_IN_WR:
            begin
                we     = 1'b1;
                wd     = rd_data_reg;
                k_next = k_reg - COL_W'(1);
            end
            U_WR_CHAR:
            begin
                we = 1'b1;
                wa = cell_addr(page_reg, row_reg, col_reg);
                wd = item_reg.char_code;
                if (!stat.col_end)
                    col_next = col_reg + COL_W'(1);
            end
            U_NEWLINE:
            begin
                col_next = '0;
                if (!stat.row_last)
                    row_next = row_reg + ROW_W'(1);
            end
            U_CR:
            begin
                col_next = '0;
            end
            U_NP_GO:
            begin
                page_next = page_reg + PAGE_W'(1);
                row_next  = '0;
                col_next  = '0;
                if (stat.np_new)
                begin
                    cnt_next = {1'b0, page_reg} + CNT_W'(2);
                    bp_next  = page_reg + PAGE_W'(1);
                    bc_next  = '0;
                end
            end
            U_NP_FAIL_NL:
            begin
                limit_next = 1'b1;
            end
            U_NP_FAIL_HW:
            begin
                limit_next = 1'b1;
                col_next   = cmax;
            end
            U_SW_INIT:
            begin
                k_next = cmax;
            end
            U_SW_RD:
            begin
                ra = cell_addr(page_reg, row_reg, k_reg);
            end
            U_SW1_CHK:
            begin
                if (!stat.rd_space)
                    last_next = k_reg;
                k_next = k_reg - COL_W'(1);
            end
            U_SW2_CHK:
            begin
                if (stat.rd_space)
                    sp_next = k_reg;
                k_next = k_reg - COL_W'(1);
            end
            U_SW3_INIT:
            begin
                k_next = '0;
            end
            U_SW3_RD:
            begin
                ra = cell_addr(page_reg, row_reg + ROW_W'(1), k_reg);
            end
            U_K_INC:
            begin
                k_next = k_reg + COL_W'(1);
            end
            U_SW_TGT:
            begin
                k_next = '0;
                if (!stat.row_last)
                begin
                    tp_next = page_reg;
                    tr_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    tp_next = page_reg + PAGE_W'(1);
                    tr_next = '0;
                    if (stat.np_new)
                    begin
                        cnt_next = {1'b0, page_reg} + CNT_W'(2);
                        bp_next  = page_reg + PAGE_W'(1);
                        bc_next  = '0;
                    end
                end
            end
            U_CP_RD:
            begin
                ra = cell_addr(page_reg, row_reg, sp_reg + k_reg + COL_W'(1));
            end
            U_CP_WR:
            begin
                we     = 1'b1;
                wa     = cell_addr(tp_reg, tr_reg, k_reg);
                wd     = rd_data_reg;
                k_next = k_reg + COL_W'(1);
            end
            U_CP_SP:
            begin
                we     = 1'b1;
                wa     = cell_addr(tp_reg, tr_reg, k_reg);
                k_next = k_reg + COL_W'(1);
            end
            U_OLD_INIT:
            begin
                k_next = sp_reg + COL_W'(1);
            end
            U_OLD_BL:
            begin
                we     = 1'b1;
                k_next = k_reg + COL_W'(1);
            end
            U_SW_FIN:
            begin
                page_next = tp_reg;
                row_next  = tr_reg;
                col_next  = last_reg - sp_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            cnt_reg   <= CNT_W'(1);
            limit_reg <= 1'b0;
            cell_reg  <= 8'd0;
            bp_reg    <= '0;
            bc_reg    <= '0;
        end
        else
        begin
            page_reg  <= page_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            limit_reg <= limit_next;
            cell_reg  <= cell_next;
            bp_reg    <= bp_next;
            bc_reg    <= bc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        sr_reg   <= sr_next;
        sp_reg   <= sp_next;
        last_reg <= last_next;
        tp_reg   <= tp_next;
        tr_reg   <= tr_next;
        item_reg <= item_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_data_reg <= mem[ra];
    end

    always_comb
    begin
        result.cursor_page    = page_reg;
        result.cursor_row     = row_reg;
        result.cursor_col     = col_reg;
        result.pages_used     = cnt_reg;
        result.cell_value     = cell_reg;
        result.page_limit_hit = limit_reg;
    end

endmodule

/* rtl/tpge_ctrl.sv */
// ---------------------------------------------------------------------------
// tpge_ctrl
// Sequencer that walks each keystroke through datapath micro-ops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpge_ctrl
    import tpge_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_free,
    input  tpge_stat_t stat,
    output tpge_uop_t  uop,
    output logic       in_ready,
    output logic       done
);

    typedef enum logic [5:0] {
        S_BLANK, S_IDLE, S_DISP, S_READ, S_CELL, S_DONE,
        S_DEL, S_DL_RD, S_DL_WR, S_WR_LAST, S_WR_CUR, S_PS_RD, S_PS_CHK,
        S_IN_RD, S_IN_WR, S_WCHAR,
        S_SW_START, S_SW1_RD, S_SW1_CHK, S_SW2_RD, S_SW2_CHK,
        S_SW3, S_SW3_RD, S_SW3_CHK, S_SW_TGT, S_CP, S_CP_WR,
        S_OLD_INIT, S_OLD_BL, S_SW_FIN, S_HW, S_NP
    } state_t;

    typedef enum logic [1:0] {
        R_IDLE, R_DONE, R_COPY
    } ret_t;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;
    logic   hw_reg, hw_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        hw_next    = hw_reg;
        uop        = U_NOP;
        in_ready   = 1'b0;
        done       = 1'b0;
        case (state_reg)
            S_BLANK:
            begin
                uop = U_BLANK;
                if (stat.blank_end)
                begin
                    case (ret_reg)
                        R_IDLE:  state_next = S_IDLE;
                        R_COPY:  state_next = S_CP;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    uop        = U_START;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.op)
                    OP_TYPE:
                    begin
                        if (stat.ch_nl)
                        begin
                            uop = U_NEWLINE;
                            hw_next = 1'b0;
                            state_next = stat.row_last ? S_NP : S_DONE;
                        end
                        else if (stat.ch_cr)
                        begin
                            uop = U_CR;
                            state_next = S_DONE;
                        end
                        else if (stat.ch_ctl)
                            state_next = S_DONE;
                        else if (stat.shift_ok)
                        begin
                            uop = U_INS_INIT;
                            state_next = S_IN_RD;
                        end
                        else
                            state_next = S_WCHAR;
                    end
                    OP_BACK:
                    begin
                        if (!stat.col_zero)
                        begin
                            uop = U_BS_COL;
                            state_next = S_DEL;
                        end
                        else if (!stat.row_zero)
                        begin
                            uop = U_BS_ROW;
                            state_next = S_DEL;
                        end
                        else if (stat.page_zero)
                            state_next = S_DONE;
                        else
                        begin
                            uop = U_BS_PAGE;
                            state_next = S_PS_RD;
                        end
                    end
                    OP_DEL:
                        state_next = S_DEL;
                    OP_CLEAR:
                    begin
                        uop = U_CLEAR;
                        ret_next = R_DONE;
                        state_next = S_BLANK;
                    end
                    OP_READ:
                        state_next = S_READ;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_READ:
            begin
                uop = U_RD_CELL;
                state_next = S_CELL;
            end
            S_CELL:
            begin
                uop = U_CELL_OUT;
                state_next = S_DONE;
            end
            S_DEL:
            begin
                if (stat.shift_ok)
                begin
                    uop = U_DEL_INIT;
                    state_next = S_DL_RD;
                end
                else
                begin
                    uop = U_WR_CUR_SP;
                    state_next = S_DONE;
                end
            end
            S_DL_RD:
            begin
                uop = U_DL_RD;
                state_next = S_DL_WR;
            end
            S_DL_WR:
            begin
                uop = U_DL_WR;
                state_next = stat.del_end ? S_WR_LAST : S_DL_RD;
            end
            S_WR_LAST:
            begin
                uop = U_WR_LAST;
                state_next = S_DONE;
            end
            S_WR_CUR:
            begin
                uop = U_WR_CUR_SP;
                state_next = S_DONE;
            end
            S_PS_RD:
            begin
                uop = U_PS_RD;
                state_next = S_PS_CHK;
            end
            S_PS_CHK:
            begin
                uop = U_PS_CHK;
                if (!stat.rd_space)
                    state_next = S_WR_CUR;
                else if (stat.ps_end)
                    state_next = S_DONE;
                else
                    state_next = S_PS_RD;
            end
            S_IN_RD:
            begin
                uop = U_IN_RD;
                state_next = S_IN_WR;
            end
            S_IN_WR:
            begin
                uop = U_IN_WR;
                state_next = stat.ins_end ? S_WCHAR : S_IN_RD;
            end
            S_WCHAR:
            begin
                uop = U_WR_CHAR;
                if (!stat.col_end)
                    state_next = S_DONE;
                else if (stat.wrap_en)
                    state_next = S_SW_START;
                else
                    state_next = S_HW;
            end
            S_SW_START:
            begin
                uop = U_SW_INIT;
                state_next = S_SW1_RD;
            end
            S_SW1_RD:
            begin
                uop = U_SW_RD;
                state_next = S_SW1_CHK;
            end
            S_SW1_CHK:
            begin
                uop = U_SW1_CHK;
                if (stat.k_zero)
                    state_next = S_HW;
                else if (!stat.rd_space)
                    state_next = S_SW2_RD;
                else
                    state_next = S_SW1_RD;
            end
            S_SW2_RD:
            begin
                uop = U_SW_RD;
                state_next = S_SW2_CHK;
            end
            S_SW2_CHK:
            begin
                uop = U_SW2_CHK;
                if (stat.rd_space)
                    state_next = S_SW3;
                else if (stat.k_zero)
                    state_next = S_HW;
                else
                    state_next = S_SW2_RD;
            end
            S_SW3:
            begin
                if (!stat.row_last)
                begin
                    uop = U_SW3_INIT;
                    state_next = S_SW3_RD;
                end
                else if (stat.np_over)
                    state_next = S_HW;
                else
                    state_next = S_SW_TGT;
            end
            S_SW3_RD:
            begin
                uop = U_SW3_RD;
                state_next = S_SW3_CHK;
            end
            S_SW3_CHK:
            begin
                uop = U_K_INC;
                if (!stat.rd_space)
                    state_next = S_HW;
                else if (stat.k_end)
                    state_next = S_SW_TGT;
                else
                    state_next = S_SW3_RD;
            end
            S_SW_TGT:
            begin
                uop = U_SW_TGT;
                if (stat.row_last && stat.np_new)
                begin
                    ret_next = R_COPY;
                    state_next = S_BLANK;
                end
                else
                    state_next = S_CP;
            end
            S_CP:
            begin
                if (stat.src_in)
                begin
                    uop = U_CP_RD;
                    state_next = S_CP_WR;
                end
                else
                begin
                    uop = U_CP_SP;
                    state_next = stat.k_end ? S_OLD_INIT : S_CP;
                end
            end
            S_CP_WR:
            begin
                uop = U_CP_WR;
                state_next = stat.k_end ? S_OLD_INIT : S_CP;
            end
            S_OLD_INIT:
            begin
                uop = U_OLD_INIT;
                state_next = S_OLD_BL;
            end
            S_OLD_BL:
            begin
                uop = U_OLD_BL;
                if (stat.k_end)
                    state_next = S_SW_FIN;
            end
            S_SW_FIN:
            begin
                uop = U_SW_FIN;
                state_next = S_DONE;
            end
            S_HW:
            begin
                uop = U_NEWLINE;
                hw_next = 1'b1;
                state_next = stat.row_last ? S_NP : S_DONE;
            end
            S_NP:
            begin
                if (stat.np_over)
                begin
                    uop = hw_reg ? U_NP_FAIL_HW : U_NP_FAIL_NL;
                    state_next = S_DONE;
                end
                else
                begin
                    uop = U_NP_GO;
                    if (stat.np_new)
                    begin
                        ret_next = R_DONE;
                        state_next = S_BLANK;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    done = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // After reset the sequencer first blanks page 0, then goes idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BLANK;
            ret_reg   <= R_IDLE;
            hw_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            hw_reg    <= hw_next;
        end
    end

endmodule
